/* hw/rtl/crc32pp_pkg.sv */
// ----------------------------------------------------------------------------
// crc32pp_pkg
// Shared widths, types and constants for the programmable-polynomial CRC-32
// ----------------------------------------------------------------------------
`default_nettype none

package crc32pp_pkg;

    localparam int CRC_W  = 32;
    localparam int BYTE_W = 8;

    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam crc_t POLY_RESET = 32'h04C1_1DB7;

endpackage

`default_nettype wire

/* hw/rtl/crc32pp_fold.sv */
// ----------------------------------------------------------------------------
// crc32pp_fold
// Folds one byte into a 32-bit MSB-first CRC: eight shift and XOR steps
// ----------------------------------------------------------------------------
`default_nettype none

module crc32pp_fold (
    input  wire crc32pp_pkg::crc_t  crc_in,
    input  wire crc32pp_pkg::byte_t data_byte,
    input  wire crc32pp_pkg::crc_t  poly,
    output crc32pp_pkg::crc_t       crc_out
);

    always_comb begin
        crc32pp_pkg::crc_t acc;
        logic              top;
        acc = crc_in ^ {data_byte, {(crc32pp_pkg::CRC_W - crc32pp_pkg::BYTE_W){1'b0}}};
        for (int k = 0; k < crc32pp_pkg::BYTE_W; k++) begin
            top = acc[crc32pp_pkg::CRC_W-1];
            acc = {acc[crc32pp_pkg::CRC_W-2:0], 1'b0};
            if (top) begin
                acc = acc ^ poly;
            end
        end
        crc_out = acc;
    end

endmodule

`default_nettype wire

/* hw/rtl/crc32_programmable_poly.sv */
// A taken beat is held in the input register; a last beat's CRC goes to the output register.
// Throughput: one input beat per cycle; a last beat waits only while an earlier
//   result is still held on the master side.
// Reset: aresetn low clears the running CRC, empties both register stages and
//   restores the polynomial to 0x04C11DB7.
// ----------------------------------------------------------------------------
// crc32_programmable_poly
// Byte-wise MSB-first CRC-32 with programmable polynomial, zero start value,
// result emitted and register cleared on the last beat of a message
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_programmable_poly (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire [31:0] cfg_wdata,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // data_byte
    input  wire        s_tlast,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [31:0] m_tdata   // crc_value
);

    crc32pp_pkg::crc_t  poly_reg;
    crc32pp_pkg::crc_t  crc_reg;
    crc32pp_pkg::crc_t  crc_next;
    crc32pp_pkg::crc_t  crc_fold;
    logic               in_valid_reg;
    crc32pp_pkg::byte_t in_byte_reg;
    logic               in_last_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    crc32pp_pkg::crc_t  out_data_reg;
    logic               out_free;
    logic               in_move;

    crc32pp_fold u_fold (
        .crc_in    (crc_reg),
        .data_byte (in_byte_reg),
        .poly      (poly_reg),
        .crc_out   (crc_fold)
    );

    always_comb begin
        out_free       = !out_valid_reg || m_tready;
        in_move        = in_valid_reg && (!in_last_reg || out_free);
        s_tready       = !in_valid_reg || in_move;
        crc_next       = crc_reg;
        if (in_move) begin
            crc_next = in_last_reg ? '0 : crc_fold;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = in_move && in_last_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg      <= crc32pp_pkg::POLY_RESET;
            crc_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                poly_reg <= cfg_wdata;
            end
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_free && in_move && in_last_reg) begin
            out_data_reg <= crc_fold;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/crc32pp_checker.sv */
// ----------------------------------------------------------------------------
// crc32pp_checker
// Port-level checks on the CRC block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module crc32pp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        cfg_we,
    input wire [31:0] cfg_wdata,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [7:0]  s_tdata,
    input wire        s_tlast,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata
);

    // nothing left on the master side after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // a held result beat stays unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // a fresh result only follows an accepted last input beat
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result beat without a preceding last beat");

    // with the master side empty the slave side never stalls
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind crc32_programmable_poly crc32pp_checker u_crc32pp_checker (.*);

`default_nettype wire
